// ----- rtl/core/cfd_pkg.sv -----
package cfd_pkg;

    // Command codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_DUMP  = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Width of a stored entry.
    localparam int unsigned DATA_W = 32;

    // One classified command waiting between the front and the back.
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_item_t;

    // Back-end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

// ----- rtl/core/cfd_front.sv -----
module cfd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic signed [cfd_pkg::DATA_W-1:0]   push_value,
    output logic                                q_valid,
    output cfd_pkg::cmd_item_t                  q_item,
    input  logic                                q_ready
);
    import cfd_pkg::*;

    // Two-entry command queue that decouples input acceptance from execution.
    cmd_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_write;
    logic       do_read;
    cmd_item_t  new_item;

    // Classify the incoming command and package it with its value.
    always_comb
    begin
        new_item.op    = op_t'(command);
        new_item.value = push_value;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign do_write = in_valid && in_ready;
    assign do_read  = q_valid && q_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = do_write ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_write && do_read)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- rtl/core/cfd_back.sv -----
module cfd_back #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  cfd_pkg::cmd_item_t                  q_item,
    output logic                                q_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [cfd_pkg::DATA_W-1:0]   entry_value,
    output logic                                value_valid,
    output logic                                last
);
    import cfd_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Advance a ring index with wrap at DEPTH.
    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        logic [IW-1:0] res;
        if (idx == IW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IW'(1);
        end
        return res;
    endfunction

    // Ring storage, written on push and read with a registered port.
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [IW-1:0]            rd_addr;
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [IW-1:0] tail_reg;
    logic [IW-1:0] tail_next;
    logic          empty_reg;
    logic          empty_next;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] ptr_next;
    op_t           op_reg;
    op_t           op_next;

    // Output register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     vvalid_reg;
    logic                     vvalid_next;
    logic                     last_reg;
    logic                     last_next;

    logic slot_free;
    logic load;
    logic fin;

    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer: executes one command, walking the ring for dumps and closes.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        ptr_next    = ptr_reg;
        op_next     = op_reg;
        q_ready     = 1'b0;
        load        = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        vvalid_next = vvalid_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = next_slot(tail_reg);
        rd_addr     = head_reg;
        fin         = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_ready = 1'b1;
                    case (q_item.op)
                        OP_PUSH:
                        begin
                            load        = 1'b1;
                            value_next  = '0;
                            vvalid_next = 1'b0;
                            last_next   = 1'b1;
                            if (!empty_reg && next_slot(tail_reg) == head_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                mem_we      = 1'b1;
                                if (empty_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b0;
                                    mem_waddr  = '0;
                                end
                                else
                                begin
                                    tail_next = next_slot(tail_reg);
                                end
                            end
                        end
                        default:
                        begin
                            if (empty_reg)
                            begin
                                load        = 1'b1;
                                status_next = ST_EMPTY;
                                value_next  = '0;
                                vvalid_next = 1'b0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                op_next    = q_item.op;
                                ptr_next   = head_reg;
                                state_next = BK_READ;
                            end
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                rd_addr = ptr_reg;
                if (slot_free)
                begin
                    fin         = (op_reg == OP_POP) || (ptr_reg == tail_reg);
                    load        = 1'b1;
                    status_next = ST_OK;
                    value_next  = rd_data_reg;
                    vvalid_next = 1'b1;
                    last_next   = fin;
                    if (op_reg == OP_POP)
                    begin
                        state_next = BK_IDLE;
                        if (head_reg == tail_reg)
                        begin
                            empty_next = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                        end
                        else
                        begin
                            head_next = next_slot(head_reg);
                        end
                    end
                    else if (fin)
                    begin
                        state_next = BK_IDLE;
                        if (op_reg == OP_CLOSE)
                        begin
                            empty_next = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                        end
                    end
                    else
                    begin
                        ptr_next = next_slot(ptr_reg);
                        rd_addr  = ptr_next;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            ptr_reg       <= '0;
            op_reg        <= OP_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            ptr_reg       <= ptr_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        vvalid_reg <= vvalid_next;
        last_reg   <= last_next;
    end

    // Ring memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_item.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_value = value_reg;
    assign value_valid = vvalid_reg;
    assign last        = last_reg;

endmodule

// ----- rtl/core/circular_fifo_with_dump_top.sv -----
// Path: push, and any command on an empty queue, passes the front queue slot and then
// the output register; pop, dump and close also pass BK_READ and the registered read.
// Throughput: push one item per cycle while the output register is free; the back takes
// no new command while a pop, dump or close reads entries through the single read port.
// Reset: rst_n clears the indices, sets the queue empty and drops queued commands;
// the entry memory is not cleared.
module circular_fifo_with_dump_top #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic signed [cfd_pkg::DATA_W-1:0]   push_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [cfd_pkg::DATA_W-1:0]   entry_value,
    output logic                                value_valid,
    output logic                                last
);
    import cfd_pkg::*;

    logic      q_valid;
    logic      q_ready;
    cmd_item_t q_item;

    // Front: accepts and classifies commands into a short queue.
    cfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .push_value (push_value),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_ready    (q_ready)
    );

    // Back: owns the ring and produces the results.
    cfd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_ready     (q_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_value (entry_value),
        .value_valid (value_valid),
        .last        (last)
    );

    // A result carrying an entry always reports success.
    a_entry_ok : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_valid |-> status == ST_OK)
        else $error("entry result with non-ok status");

    // A result without an entry shows a zero value.
    a_no_entry_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !value_valid |-> entry_value == '0)
        else $error("nonzero value without entry");

    // Full and empty reports are single results and so end their run.
    a_error_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !value_valid)
        else $error("error result not marked last");

    // The back never takes a command that the front has not offered.
    a_queue_handshake : assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid)
        else $error("command taken from empty queue");

endmodule

// ----- tb/tb_circular_fifo_with_dump_top.sv -----
`timescale 1ns / 100ps

module tb_circular_fifo_with_dump_top;

    import cfd_pkg::*;

    localparam int          DEPTH       = 8;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned SETTLE_PAD  = 20;
    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam int unsigned REPORT_MAX  = 10;

    // One result as it leaves the block.
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic                     value_valid;
        logic                     last;
    } fifo_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic [1:0]               command     = OP_PUSH;
    logic signed [DATA_W-1:0] push_value  = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic                     value_valid;
    logic                     last;

    // Items waiting to be offered and results the ring still owes.
    cmd_item_t    pending_cmds[$];
    fifo_result_t fifo_results_due[$];

    // Shadow copy of the ring state.
    logic signed [DATA_W-1:0] ring_mem [DEPTH];
    int unsigned              ring_head  = 0;
    int unsigned              ring_tail  = 0;
    bit                       ring_empty = 1'b1;

    bit          idle_on        = 1'b1;
    int unsigned send_gap       = 0;
    int unsigned recv_gap       = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    circular_fifo_with_dump_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .entry_value(entry_value),
        .value_valid(value_valid),
        .last       (last)
    );

    always #10 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return OP_PUSH;
        else if (r < 75)
            return OP_POP;
        else if (r < 90)
            return OP_DUMP;
        else
            return OP_CLOSE;
    endfunction

    function automatic void owe_result(logic [1:0] st, logic signed [DATA_W-1:0] val,
                                       logic vld, logic fin);
        fifo_results_due.push_back('{st, val, vld, fin});
    endfunction

    // Apply one accepted command to the shadow ring and record what it must emit.
    function automatic void ring_apply(op_t op, logic signed [DATA_W-1:0] val);
        int unsigned slot;
        int unsigned n;
        bit          fin;
        case (op)
            OP_PUSH:
            begin
                if (!ring_empty && (ring_tail + 1) % DEPTH == ring_head)
                    owe_result(ST_FULL, '0, 1'b0, 1'b1);
                else
                begin
                    if (ring_empty)
                    begin
                        ring_head  = 0;
                        ring_tail  = 0;
                        ring_empty = 1'b0;
                    end
                    else
                        ring_tail = (ring_tail + 1) % DEPTH;
                    ring_mem[ring_tail] = val;
                    owe_result(ST_OK, '0, 1'b0, 1'b1);
                end
            end
            OP_POP:
            begin
                if (ring_empty)
                    owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
                else
                begin
                    owe_result(ST_OK, ring_mem[ring_head], 1'b1, 1'b1);
                    if (ring_head == ring_tail)
                    begin
                        ring_empty = 1'b1;
                        ring_head  = 0;
                        ring_tail  = 0;
                    end
                    else
                        ring_head = (ring_head + 1) % DEPTH;
                end
            end
            default:
            begin
                // Dump and close emit the same run; close then empties the ring.
                if (ring_empty)
                    owe_result(ST_EMPTY, '0, 1'b0, 1'b1);
                else
                begin
                    slot = ring_head;
                    n    = 0;
                    fin  = 1'b0;
                    while (!fin)
                    begin
                        fin = (slot == ring_tail) || (n == DEPTH - 1);
                        owe_result(ST_OK, ring_mem[slot], 1'b1, fin);
                        n++;
                        slot = (slot + 1) % DEPTH;
                    end
                end
                if (op == OP_CLOSE)
                begin
                    ring_empty = 1'b1;
                    ring_head  = 0;
                    ring_tail  = 0;
                end
            end
        endcase
    endfunction

    task automatic queue_item(op_t op, logic signed [DATA_W-1:0] val);
        pending_cmds.push_back('{op, val});
    endtask

    // Random commands, with an occasional run that fills the ring past full.
    task automatic queue_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                for (int k = 0; k <= DEPTH; k++)
                    queue_item(OP_PUSH, pick_value());
                queue_item($urandom_range(0, 1) ? OP_DUMP : OP_CLOSE, pick_value());
            end
            else
                queue_item(pick_op(), pick_value());
        end
    endtask

    // Wait until every item went in and every owed result came out.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || fifo_results_due.size() != 0);
    endtask

    // Sender: offers items from the pending queue with random gaps between them.
    always @(posedge clk)
    begin
        cmd_item_t next_item;
        logic      offering;
        offering = in_valid;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                ring_apply(op_t'(command), push_value);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_item = pending_cmds.pop_front();
                    in_valid   <= 1'b1;
                    command    <= next_item.op;
                    push_value <= next_item.value;
                    send_gap = idle_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here and started on request.
    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each accepted result against the oldest owed one.
    always @(posedge clk)
    begin
        fifo_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (fifo_results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: status=%0d value=%0d valid=%0b last=%0b",
                                 status, entry_value, value_valid, last);
                end
                else
                begin
                    want = fifo_results_due.pop_front();
                    if (status !== want.status || entry_value !== want.value ||
                        value_valid !== want.value_valid || last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("result mismatch: expected status=%0d value=%0d %s",
                                     want.status, want.value, "");
                            $display("    expected valid=%0b last=%0b",
                                     want.value_valid, want.last);
                            $display("    got status=%0d value=%0d valid=%0b last=%0b",
                                     status, entry_value, value_valid, last);
                        end
                    end
                end
                recv_gap = idle_gap();
            end
            if (recv_gap != 0)
            begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (hold_left == 0);
        end
    end

    // Cycle limit for a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            ring_mem[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty-queue cases, fill to full, overflow, wrap, dump and close.
        queue_item(OP_POP, 32'sd0);
        queue_item(OP_DUMP, '1);
        queue_item(OP_CLOSE, 32'sd0);
        queue_item(OP_PUSH, 32'h7FFF_FFFF);
        queue_item(OP_PUSH, 32'h8000_0000);
        queue_item(OP_PUSH, 32'h0000_0000);
        queue_item(OP_PUSH, 32'hFFFF_FFFF);
        queue_item(OP_PUSH, 32'h0000_0001);
        queue_item(OP_PUSH, 32'h5555_5555);
        queue_item(OP_PUSH, 32'hAAAA_AAAA);
        queue_item(OP_PUSH, 32'sd5);
        queue_item(OP_PUSH, 32'h0BAD_F00D);
        queue_item(OP_DUMP, 32'sd0);
        queue_item(OP_POP, 32'sd0);
        queue_item(OP_PUSH, 32'h1234_5678);
        queue_item(OP_DUMP, 32'sd0);
        queue_item(OP_CLOSE, 32'sd0);
        queue_item(OP_POP, 32'sd0);
        queue_item(OP_PUSH, 32'sd42);
        queue_item(OP_POP, 32'sd0);
        queue_item(OP_POP, 32'sd0);
        queue_item(OP_PUSH, -32'sd7);
        queue_item(OP_PUSH, 32'sd9);
        queue_item(OP_DUMP, 32'sd0);
        queue_item(OP_CLOSE, 32'sd0);
        queue_item(OP_DUMP, 32'sd0);
        drain();

        // Random traffic with idling on both sides.
        queue_random(15);
        drain();

        // A stretch with no idling at all.
        idle_on = 1'b0;
        queue_random(10);
        drain();

        // Receiver holds off while the sender keeps offering, so the block backs up.
        hold_asks = hold_asks + 1;
        queue_random(10);
        drain();

        idle_on = 1'b1;
        queue_random(8);
        drain();

        repeat (SETTLE_PAD) @(posedge clk);
        if (mismatch_count == 0 && fifo_results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
